// File: hw/rtl/ims_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and constants for the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam int COORD_W  = 6;
  localparam int COORD_N  = 64;
  localparam int DRAW_W   = 16;
  localparam int SLOT_W   = 17;
  localparam int NUM_SLOT = 10;
  localparam int TBL_W    = SLOT_W * NUM_SLOT;
  localparam int MAG_W    = 14;
  localparam int EN_W     = 15;
  localparam int REG_W    = 3 * SLOT_W;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 64;

  typedef enum logic [1:0] {
    REG_TBL0 = 2'd0,
    REG_TBL1 = 2'd1,
    REG_TBL2 = 2'd2,
    REG_TBL3 = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ROW_MID = 2'd0,
    ROW_UP  = 2'd1,
    ROW_DN  = 2'd2
  } row_sel_e;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    row_sel_e rd_sel;
    logic     lat_mid;
    logic     lat_up;
    logic     lat_dn;
    logic     commit;
  } ims_cmd_t;

  typedef struct packed {
    logic is_trial;
    logic out_free;
  } ims_sts_t;

  // slot = 5 * spin + number of up neighbours
  function automatic logic [SLOT_W-1:0] thr_sel(logic [TBL_W-1:0] tbl, logic spin,
                                                logic [2:0] ups);
    logic [3:0] idx;
    idx = (spin ? 4'd5 : 4'd0) + 4'(ups);
    return tbl[idx*SLOT_W +: SLOT_W];
  endfunction

endpackage

// File: hw/rtl/ims_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_if
// Valid/ready channels for trial items and result items.
// ----------------------------------------------------------------------------
interface ims_in_if;
  import ims_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [DRAW_W-1:0]  draw;

  modport source (output valid, action, row, col, draw, input ready);
  modport sink   (input valid, action, row, col, draw, output ready);
endinterface

interface ims_out_if;
  import ims_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    spin_up;
  logic                    flipped;
  logic signed [MAG_W-1:0] magnet_total;
  logic signed [EN_W-1:0]  bond_energy;

  modport source (output valid, spin_up, flipped, magnet_total, bond_energy, input ready);
  modport sink   (input valid, spin_up, flipped, magnet_total, bond_energy, output ready);
endinterface

// File: hw/rtl/ims_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ims_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ims_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_cfg
// APB register file holding the acceptance threshold table.
// ----------------------------------------------------------------------------
module ims_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ims_pkg::CFG_AW-1:0]  paddr,
  input  logic [ims_pkg::CFG_DW-1:0]  pwdata,
  output logic [ims_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [ims_pkg::TBL_W-1:0]   thr_tbl_o
);
  import ims_pkg::*;

  logic [REG_W-1:0]  tbl0_q, tbl1_q, tbl2_q;
  logic [SLOT_W-1:0] tbl3_q;
  reg_idx_e          idx;
  logic              wr_en;

  assign idx    = reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl0_q <= '0;
      tbl1_q <= '0;
      tbl2_q <= '0;
      tbl3_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_TBL0: tbl0_q <= pwdata[REG_W-1:0];
        REG_TBL1: tbl1_q <= pwdata[REG_W-1:0];
        REG_TBL2: tbl2_q <= pwdata[REG_W-1:0];
        REG_TBL3: tbl3_q <= pwdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TBL0: prdata = CFG_DW'(tbl0_q);
      REG_TBL1: prdata = CFG_DW'(tbl1_q);
      REG_TBL2: prdata = CFG_DW'(tbl2_q);
      REG_TBL3: prdata = CFG_DW'(tbl3_q);
      default:  prdata = '0;
    endcase
  end

  assign thr_tbl_o = {tbl3_q, tbl2_q, tbl1_q, tbl0_q};

endmodule

// File: hw/rtl/ims_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_ctrl
// Sequencer: up to three row reads (one for a read item) through one RAM port, then commit.
// ----------------------------------------------------------------------------
module ims_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ims_pkg::ims_sts_t sts_i,
  output ims_pkg::ims_cmd_t cmd_o
);
  import ims_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_MID,
    S_RD_UP,
    S_RD_DN,
    S_LAT_DN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = ROW_MID;
    in_ready_o = 1'b0;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_RD_MID;
        end
      end
      S_RD_MID: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ROW_MID;
        state_d      = S_RD_UP;
      end
      S_RD_UP: begin
        cmd_o.lat_mid = 1'b1;
        cmd_o.rd_en   = sts_i.is_trial;
        cmd_o.rd_sel  = ROW_UP;
        state_d       = sts_i.is_trial ? S_RD_DN : S_COMMIT;
      end
      S_RD_DN: begin
        cmd_o.lat_up = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ROW_DN;
        state_d      = S_LAT_DN;
      end
      S_LAT_DN: begin
        cmd_o.lat_dn = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/ims_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ims_dp
// Lattice row store, neighbour sum, threshold test and running totals.
// ----------------------------------------------------------------------------
module ims_dp #(
  parameter int SIDE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ims_pkg::ims_cmd_t                 cmd_i,
  output ims_pkg::ims_sts_t                 sts_o,
  input  logic [ims_pkg::TBL_W-1:0]         thr_tbl_i,
  input  logic                              in_action_i,
  input  logic [ims_pkg::COORD_W-1:0]       in_row_i,
  input  logic [ims_pkg::COORD_W-1:0]       in_col_i,
  input  logic [ims_pkg::DRAW_W-1:0]        in_draw_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_spin_up_o,
  output logic                              out_flipped_o,
  output logic signed [ims_pkg::MAG_W-1:0]  out_magnet_o,
  output logic signed [ims_pkg::EN_W-1:0]   out_energy_o
);
  import ims_pkg::*;

  localparam int RW = $clog2(SIDE);
  localparam logic [MAG_W-1:0] MAG_RST = MAG_W'(SIDE * SIDE);
  localparam logic [EN_W-1:0]  EN_RST  = EN_W'(-2 * SIDE * SIDE);

  logic [RW-1:0]     mod_tbl [COORD_N];
  logic [RW-1:0]     r_q, c_q, r_up, r_dn, c_lf, c_rt, raddr;
  logic [DRAW_W-1:0] draw_q;
  logic              trial_q;
  logic [SIDE-1:0]   row_vld_q;
  logic              rd_vld_q;
  logic [SIDE-1:0]   ram_rdata, rd_row, mid_q, up_q, dn_q;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [EN_W-1:0]   en_q, en_d, de;
  logic [2:0]        ups;
  logic              spin, flip, wr_en;
  logic [SLOT_W-1:0] thr;
  logic              out_vld_q, spin_out_q, flip_out_q;
  logic [MAG_W-1:0]  mag_out_q;
  logic [EN_W-1:0]   en_out_q;

  for (genvar g = 0; g < COORD_N; g++) begin : g_mod
    assign mod_tbl[g] = RW'(g % SIDE);
  end

  assign r_up = (r_q == '0) ? RW'(SIDE - 1) : r_q - RW'(1);
  assign r_dn = (r_q == RW'(SIDE - 1)) ? '0 : r_q + RW'(1);
  assign c_lf = (c_q == '0) ? RW'(SIDE - 1) : c_q - RW'(1);
  assign c_rt = (c_q == RW'(SIDE - 1)) ? '0 : c_q + RW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      ROW_MID: raddr = r_q;
      ROW_UP:  raddr = r_up;
      ROW_DN:  raddr = r_dn;
      default: raddr = r_q;
    endcase
  end

  ims_ram #(
    .WIDTH(SIDE),
    .DEPTH(SIDE)
  ) u_lattice (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(r_q),
    .wdata_i(mid_q ^ (SIDE'(1) << c_q)),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // rows never written read as all spins up
  assign rd_row = rd_vld_q ? ram_rdata : '1;

  assign spin = mid_q[c_q];
  assign ups  = 3'(mid_q[c_lf]) + 3'(mid_q[c_rt]) + 3'(up_q[c_q]) + 3'(dn_q[c_q]);
  assign thr  = thr_sel(thr_tbl_i, spin, ups);
  assign flip = trial_q && ({1'b0, draw_q} < thr);
  assign wr_en = cmd_i.commit && flip;
  assign de   = EN_W'({ups, 2'b00}) - EN_W'(8);

  always_comb begin
    mag_d = mag_q;
    en_d  = en_q;
    if (flip) begin
      if (spin) begin
        mag_d = mag_q - MAG_W'(2);
        en_d  = en_q + de;
      end else begin
        mag_d = mag_q + MAG_W'(2);
        en_d  = en_q - de;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_q     <= mod_tbl[in_row_i];
      c_q     <= mod_tbl[in_col_i];
      draw_q  <= in_draw_i;
      trial_q <= !in_action_i;
    end
    if (cmd_i.rd_en) begin
      rd_vld_q <= row_vld_q[raddr];
    end
    if (cmd_i.lat_mid) begin
      mid_q <= rd_row;
    end
    if (cmd_i.lat_up) begin
      up_q <= rd_row;
    end
    if (cmd_i.lat_dn) begin
      dn_q <= rd_row;
    end
    if (cmd_i.commit) begin
      spin_out_q <= spin ^ flip;
      flip_out_q <= flip;
      mag_out_q  <= mag_d;
      en_out_q   <= en_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      mag_q     <= MAG_RST;
      en_q      <= EN_RST;
      out_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[r_q] <= 1'b1;
      end
      if (cmd_i.commit) begin
        mag_q     <= mag_d;
        en_q      <= en_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_trial = trial_q;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o   = out_vld_q;
  assign out_spin_up_o = spin_out_q;
  assign out_flipped_o = flip_out_q;
  assign out_magnet_o  = mag_out_q;
  assign out_energy_o  = en_out_q;

endmodule

// File: hw/rtl/ising_metropolis_site_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis single-site update on a periodic SIDE x SIDE spin lattice.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        action, row, col, draw
//   out_o    out  valid/ready        spin_up, flipped, magnet_total, bond_energy
//   apb      in   psel/penable/...   accept_table_0..3 at 8*i
//
// A trial item steps RD_MID, RD_UP, RD_DN, LAT_DN and COMMIT, a read item
// RD_MID, RD_UP and COMMIT; row reads go one at a time through the RAM port.
// The result register lets the next item start while a result waits.
// After reset the lattice reads all +1 through per-row valid flags; no
// clearing pass is needed. A stalled output holds the block in its commit step.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update #(
  parameter int SIDE = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ims_in_if.sink                      in_i,
  ims_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ims_pkg::CFG_AW-1:0]  paddr,
  input  logic [ims_pkg::CFG_DW-1:0]  pwdata,
  output logic [ims_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import ims_pkg::*;

  ims_cmd_t         cmd;
  ims_sts_t         sts;
  logic [TBL_W-1:0] thr_tbl;
  logic             in_ready;

  ims_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .thr_tbl_o(thr_tbl)
  );

  ims_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  assign in_i.ready = in_ready;

  ims_dp #(
    .SIDE(SIDE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .thr_tbl_i    (thr_tbl),
    .in_action_i  (in_i.action),
    .in_row_i     (in_i.row),
    .in_col_i     (in_i.col),
    .in_draw_i    (in_i.draw),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_spin_up_o(out_o.spin_up),
    .out_flipped_o(out_o.flipped),
    .out_magnet_o (out_o.magnet_total),
    .out_energy_o (out_o.bond_energy)
  );

endmodule
